>>> src/cmtc_pkg.sv
package cmtc_pkg;

    localparam int ROOT_ITER_BITS_DEF = 16;
    localparam int POW_TABLE_BITS_DEF = 8;
    localparam int POW_TABLE_MAX      = 12;

    localparam logic [16:0] POROSITY_ONE = 17'd65536;
    localparam logic [31:0] RADIUS_RESET = 32'd65536;

    localparam logic [36:0] DIV5_MUL   = 37'd109951162777;
    localparam logic [40:0] LOG2_055   = 41'h1FFC8CCDB94;
    localparam logic [37:0] LRE_BIAS   = 38'd31 << 30;
    localparam logic [40:0] LT_OFFSET  = 41'd16 << 30;

    typedef struct packed {
        logic [16:0]        porosity;
        logic [16:0]        initial_porosity;
        logic [31:0]        density;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic [31:0]        viscosity;
        logic [31:0]        diffusivity;
    } item_t;

    typedef struct packed {
        logic [47:0] transfer_coefficient;
        logic        overflow;
    } result_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } root_t;

    function automatic root_t root_step(input logic [63:0] rem, input logic [31:0] root,
                                        input int b);
        logic [65:0] trial;
        root_t       res;
        trial    = ({34'd0, root} << (b + 1)) + (66'd1 << (2 * b));
        res.rem  = rem;
        res.root = root;
        if (trial <= {2'b00, rem})
        begin
            res.rem  = rem - trial[63:0];
            res.root = root | (32'd1 << b);
        end
        return res;
    endfunction

    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [POW_TABLE_MAX:1][31:0] pow_factors();
        logic [POW_TABLE_MAX:1][31:0] tab;
        logic [63:0]                  fac;
        logic [63:0]                  x;
        logic [63:0]                  c;
        logic [63:0]                  root;
        fac = 64'd2 << 30;
        for (int k = 1; k <= POW_TABLE_MAX; k++)
        begin
            x    = fac << 30;
            root = 64'd0;
            for (int i = 0; i < 32; i++)
            begin
                c = root | (64'd1 << (31 - i));
                if (c * c <= x)
                begin
                    root = c;
                end
            end
            tab[k] = root[31:0];
            fac    = root;
        end
        return tab;
    endfunction

endpackage

>>> src/cylinder_mass_transfer_coefficient_core.sv
// Throughput: one cell per cycle while no result is stalled; every stage is a register, with the 64-step
// quotient chain and the two bitwise root chains setting the depth.
// A stalled result freezes the whole pipe and holds the input stall high.
// Reset (rst_n low, asynchronous) clears all valid bits and sets the radius to 1.0.
module cylinder_mass_transfer_coefficient_core #(
    parameter int ROOT_ITER_BITS = cmtc_pkg::ROOT_ITER_BITS_DEF,
    parameter int POW_TABLE_BITS = cmtc_pkg::POW_TABLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [31:0]       cfg_write_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  cmtc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cmtc_pkg::result_t result
);

    localparam int RB      = (ROOT_ITER_BITS + 16 > 32) ? 32 : ROOT_ITER_BITS + 16;
    localparam int PTB     = POW_TABLE_BITS;
    localparam int J_SQ0   = 2;
    localparam int J_NUM   = J_SQ0 + RB;
    localparam int J_LOG0  = J_NUM + 1;
    localparam int J_LRE   = J_LOG0 + PTB;
    localparam int J_D5A   = J_LRE + 1;
    localparam int J_D5B   = J_D5A + 1;
    localparam int J_D5C   = J_D5B + 1;
    localparam int J_LT    = J_D5C + 1;
    localparam int J_ACC0  = J_LT + 1;
    localparam int J_DIV0  = J_ACC0 + PTB;
    localparam int J_PP    = J_DIV0 + 64;
    localparam int J_PR    = J_PP + 1;
    localparam int J_SH    = J_PR + 1;
    localparam int J_OUT   = J_SH + 1;
    localparam int N       = J_OUT + 1;

    localparam int LOG_R   = 0;
    localparam int LOG_RHO = 1;
    localparam int LOG_SPD = 2;
    localparam int LOG_MU  = 3;

    localparam logic [cmtc_pkg::POW_TABLE_MAX:1][31:0] POW_FACTOR = cmtc_pkg::pow_factors();

    typedef struct packed {
        logic [32:0]               pprod;
        logic [31:0]               alpha;
        logic [31:0]               rho;
        logic [31:0]               mu;
        logic [62:0]               sqx;
        logic [62:0]               sqy;
        logic [62:0]               sqz;
        logic [63:0]               srem;
        logic [31:0]               sroot;
        logic [63:0]               urem;
        logic [31:0]               uroot;
        logic [3:0][31:0]          lm;
        logic [3:0][4:0]           ln;
        logic [3:0][PTB-1:0]       lf;
        logic [35:0]               lr;
        logic                      neg;
        logic [38:0]               amag;
        logic [56:0]               d5h;
        logic [55:0]               d5l;
        logic [36:0]               q;
        logic [7:0]                ip;
        logic [29:0]               f;
        logic [31:0]               acc;
        logic [31:0]               drem;
        logic [63:0]               dq;
        logic [63:0]               mpl;
        logic [63:0]               mph;
        logic [95:0]               prod;
        logic [6:0]                s2;
        logic [47:0]               term;
        logic                      tsat;
        logic                      nz_use;
        logic                      zero_ovr;
        logic [47:0]               tc;
        logic                      ovf;
    } pipe_t;

    logic [31:0]  radius_reg;
    logic [N-1:0] vld_reg;
    pipe_t        stg_reg  [N];
    pipe_t        stg_next [N];
    logic         en;

    assign en           = !(vld_reg[N-1] && result_stall);
    assign item_stall   = !en;
    assign result_valid = vld_reg[N-1];
    assign result.transfer_coefficient = stg_reg[N-1].tc;
    assign result.overflow             = stg_reg[N-1].ovf;

    always_comb
    begin
        logic [16:0]       pc;
        logic [16:0]       p0c;
        logic [31:0]       ax;
        logic [31:0]       ay;
        logic [31:0]       az;
        logic [63:0]       mm;
        logic [32:0]       msq;
        logic [48:0]       num49;
        logic [31:0]       lv_in;
        logic [4:0]        nl;
        logic [3:0][35:0]  lv;
        logic [37:0]       lre;
        logic [39:0]       t3;
        logic [75:0]       d5sum;
        logic [39:0]       rr;
        logic [40:0]       qs;
        logic [40:0]       lt;
        logic [32:0]       remt;
        logic [32:0]       remd;
        logic [8:0]        s2w;
        logic [111:0]      shv;
        logic [47:0]       tuse;
        logic [50:0]       total;
        logic              use_t;
        logic              sat;
        cmtc_pkg::root_t   rs;

        stg_next[0] = '0;
        pc  = (item.porosity > cmtc_pkg::POROSITY_ONE) ? cmtc_pkg::POROSITY_ONE
                                                       : item.porosity;
        p0c = (item.initial_porosity > cmtc_pkg::POROSITY_ONE) ? cmtc_pkg::POROSITY_ONE
                                                               : item.initial_porosity;
        stg_next[0].pprod = {16'd0, cmtc_pkg::POROSITY_ONE - pc}
                          * {16'd0, cmtc_pkg::POROSITY_ONE - p0c};
        ax = item.velocity_x[31] ? (~item.velocity_x + 32'd1) : item.velocity_x;
        ay = item.velocity_y[31] ? (~item.velocity_y + 32'd1) : item.velocity_y;
        az = item.velocity_z[31] ? (~item.velocity_z + 32'd1) : item.velocity_z;
        mm = {32'd0, ax} * {32'd0, ax};
        stg_next[0].sqx = mm[62:0];
        mm = {32'd0, ay} * {32'd0, ay};
        stg_next[0].sqy = mm[62:0];
        mm = {32'd0, az} * {32'd0, az};
        stg_next[0].sqz = mm[62:0];
        stg_next[0].alpha    = item.diffusivity;
        stg_next[0].rho      = item.density;
        stg_next[0].mu       = item.viscosity;
        stg_next[0].zero_ovr = (radius_reg == 32'd0) || (item.viscosity == 32'd0);

        stg_next[1]       = stg_reg[0];
        stg_next[1].urem  = {1'b0, stg_reg[0].sqx} + {1'b0, stg_reg[0].sqy}
                          + {1'b0, stg_reg[0].sqz};
        stg_next[1].srem  = {31'd0, stg_reg[0].pprod};
        stg_next[1].sroot = 32'd0;
        stg_next[1].uroot = 32'd0;

        for (int j = J_SQ0; j < J_NUM; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            rs = cmtc_pkg::root_step(stg_reg[j-1].srem, stg_reg[j-1].sroot, 31 - (j - J_SQ0));
            stg_next[j].srem  = rs.rem;
            stg_next[j].sroot = rs.root;
            rs = cmtc_pkg::root_step(stg_reg[j-1].urem, stg_reg[j-1].uroot, 31 - (j - J_SQ0));
            stg_next[j].urem  = rs.rem;
            stg_next[j].uroot = rs.root;
        end

        stg_next[J_NUM] = stg_reg[J_NUM-1];
        num49 = {32'd0, stg_reg[J_NUM-1].sroot[16:0]} * {17'd0, stg_reg[J_NUM-1].alpha};
        stg_next[J_NUM].dq     = {num49, 15'd0};
        stg_next[J_NUM].drem   = 32'd0;
        stg_next[J_NUM].nz_use = (stg_reg[J_NUM-1].rho != 32'd0)
                              && (stg_reg[J_NUM-1].uroot != 32'd0);
        for (int i = 0; i < 4; i++)
        begin
            case (i)
                LOG_R:   lv_in = radius_reg;
                LOG_RHO: lv_in = stg_reg[J_NUM-1].rho;
                LOG_SPD: lv_in = stg_reg[J_NUM-1].uroot;
                default: lv_in = stg_reg[J_NUM-1].mu;
            endcase
            nl = cmtc_pkg::lead_one(lv_in);
            stg_next[J_NUM].lm[i] = lv_in << (5'd31 - nl);
            stg_next[J_NUM].ln[i] = nl;
            stg_next[J_NUM].lf[i] = '0;
        end

        for (int j = J_LOG0; j < J_LRE; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            for (int i = 0; i < 4; i++)
            begin
                mm  = {32'd0, stg_reg[j-1].lm[i]} * {32'd0, stg_reg[j-1].lm[i]};
                msq = mm[63:31];
                stg_next[j].lm[i] = msq[32] ? msq[32:1] : msq[31:0];
                stg_next[j].lf[i] = {stg_reg[j-1].lf[i][PTB-2:0], msq[32]};
            end
        end

        stg_next[J_LRE] = stg_reg[J_LRE-1];
        for (int i = 0; i < 4; i++)
        begin
            lv[i] = {1'b0, stg_reg[J_LRE-1].ln[i], 30'd0}
                  + ({{(36-PTB){1'b0}}, stg_reg[J_LRE-1].lf[i]} << (30 - PTB));
        end
        lre = {2'b00, lv[LOG_R]} + {2'b00, lv[LOG_RHO]} + {2'b00, lv[LOG_SPD]}
            - {2'b00, lv[LOG_MU]} - cmtc_pkg::LRE_BIAS;
        t3  = {lre[37], lre[37], lre} + {lre[37], lre, 1'b0};
        stg_next[J_LRE].neg  = t3[39];
        stg_next[J_LRE].amag = t3[39] ? 39'(~t3 + 40'd1) : t3[38:0];
        stg_next[J_LRE].lr   = lv[LOG_R];

        stg_next[J_D5A]     = stg_reg[J_D5A-1];
        stg_next[J_D5A].d5h = {37'd0, stg_reg[J_D5A-1].amag[38:19]}
                            * {20'd0, cmtc_pkg::DIV5_MUL};
        stg_next[J_D5A].d5l = {37'd0, stg_reg[J_D5A-1].amag[18:0]}
                            * {19'd0, cmtc_pkg::DIV5_MUL};

        stg_next[J_D5B]   = stg_reg[J_D5B-1];
        d5sum = {stg_reg[J_D5B-1].d5h, 19'd0} + {20'd0, stg_reg[J_D5B-1].d5l};
        stg_next[J_D5B].q = d5sum[75:39];

        stg_next[J_D5C] = stg_reg[J_D5C-1];
        rr = {1'b0, stg_reg[J_D5C-1].amag}
           - ({1'b0, stg_reg[J_D5C-1].q, 2'b00} + {3'd0, stg_reg[J_D5C-1].q});
        if (rr >= 40'd5)
        begin
            stg_next[J_D5C].q = stg_reg[J_D5C-1].q + 37'd1;
        end

        stg_next[J_LT] = stg_reg[J_LT-1];
        qs = stg_reg[J_LT-1].neg ? (~{4'd0, stg_reg[J_LT-1].q} + 41'd1)
                                 : {4'd0, stg_reg[J_LT-1].q};
        lt = qs + cmtc_pkg::LOG2_055 - {5'd0, stg_reg[J_LT-1].lr} + cmtc_pkg::LT_OFFSET;
        stg_next[J_LT].ip  = lt[37:30];
        stg_next[J_LT].f   = lt[29:0];
        stg_next[J_LT].acc = 32'd1 << 30;

        for (int j = J_ACC0; j < J_DIV0; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            if (stg_reg[j-1].f[29 - (j - J_ACC0)])
            begin
                mm = {32'd0, stg_reg[j-1].acc} * {32'd0, POW_FACTOR[j - J_ACC0 + 1]};
                stg_next[j].acc = mm[61:30];
            end
        end

        for (int j = J_DIV0; j < J_PP; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            remt = {stg_reg[j-1].drem, stg_reg[j-1].dq[63]};
            remd = remt - {1'b0, radius_reg};
            stg_next[j].drem = (remt >= {1'b0, radius_reg}) ? remd[31:0] : remt[31:0];
            stg_next[j].dq   = {stg_reg[j-1].dq[62:0], remt >= {1'b0, radius_reg}};
        end

        stg_next[J_PP]     = stg_reg[J_PP-1];
        stg_next[J_PP].mpl = {32'd0, stg_reg[J_PP-1].dq[31:0]} * {32'd0, stg_reg[J_PP-1].acc};
        stg_next[J_PP].mph = {32'd0, stg_reg[J_PP-1].dq[63:32]} * {32'd0, stg_reg[J_PP-1].acc};

        stg_next[J_PR]      = stg_reg[J_PR-1];
        stg_next[J_PR].prod = {stg_reg[J_PR-1].mph, 32'd0} + {32'd0, stg_reg[J_PR-1].mpl};
        s2w = 9'd60 - {stg_reg[J_PR-1].ip[7], stg_reg[J_PR-1].ip};
        stg_next[J_PR].s2   = s2w[6:0];

        stg_next[J_SH]      = stg_reg[J_SH-1];
        shv = {stg_reg[J_SH-1].prod, 16'd0} >> stg_reg[J_SH-1].s2;
        stg_next[J_SH].term = shv[47:0];
        stg_next[J_SH].tsat = |shv[111:48];

        stg_next[J_OUT] = stg_reg[J_OUT-1];
        use_t = stg_reg[J_OUT-1].nz_use && (stg_reg[J_OUT-1].dq != 64'd0);
        tuse  = use_t ? stg_reg[J_OUT-1].term : 48'd0;
        total = {1'b0, stg_reg[J_OUT-1].dq[63:14]} + {3'd0, tuse};
        sat   = (use_t && stg_reg[J_OUT-1].tsat) || (|total[50:48])
             || stg_reg[J_OUT-1].zero_ovr;
        stg_next[J_OUT].tc  = sat ? '1 : total[47:0];
        stg_next[J_OUT].ovf = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= cmtc_pkg::RADIUS_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                radius_reg <= cfg_write_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[N-2:0], item_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < N; j++)
            begin
                stg_reg[j] <= stg_next[j];
            end
        end
    end

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           ROOT_BITS = 32;
    localparam int           POW_BITS  = 8;
    localparam logic [63:0]  OUT_MAX   = (64'd1 << 48) - 64'd1;
    localparam longint       ONE_Q30   = 64'sd1073741824;
    localparam longint       LOG2_HALF_FIFTY_FIVE = -64'sd926098540;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [31:0]         cfg_write_data;
    logic                item_valid;
    logic                item_stall;
    cmtc_pkg::item_t     item;
    logic                result_valid;
    logic                result_stall;
    cmtc_pkg::result_t   result;

    cmtc_pkg::item_t     pending_cells[$];
    cmtc_pkg::result_t   expected_results[$];
    logic [31:0]         radius;
    int                  errors;
    int                  gap_left;
    int                  stall_left;
    bit                  quiet;
    bit                  took;

    cylinder_mass_transfer_coefficient_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] bit_root(input logic [63:0] x, input int nbits);
        logic [63:0] root;
        logic [63:0] c;
        root = 64'd0;
        for (int i = 0; i < nbits && i < 32; i++)
        begin
            c = root | (64'd1 << (31 - i));
            if (c * c <= x)
            begin
                root = c;
            end
        end
        return root;
    endfunction

    function automatic longint log2_fix(input logic [63:0] v);
        int          n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 63;
        while (n > 0 && !v[n])
        begin
            n--;
        end
        m = (n >= 31) ? (v >> (n - 31)) : (v << (31 - n));
        frac = 64'd0;
        for (int i = 0; i < POW_BITS; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m[32])
            begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return longint'(n) * ONE_Q30 + longint'(frac << (30 - POW_BITS));
    endfunction

    function automatic logic [63:0] abs_vel(input logic signed [31:0] v);
        logic [63:0] raw;
        raw = {32'd0, v};
        return v[31] ? ((64'd1 << 32) - raw) : raw;
    endfunction

    function automatic cmtc_pkg::result_t predict_coefficient(input cmtc_pkg::item_t c,
                                                              input logic [31:0] rad);
        cmtc_pkg::result_t res;
        logic [63:0]  p, p0, r, s_root, num, b16, b30, vx, vy, vz, speed, term, total;
        logic [63:0]  acc, factor, hi, lo;
        logic [127:0] prod;
        longint       lr, lre, lt, ip, f, sh, kk;
        bit           sat;
        r = {32'd0, rad};
        term = 64'd0;
        sat = 1'b0;
        if (r == 0 || c.viscosity == 0)
        begin
            res.transfer_coefficient = OUT_MAX[47:0];
            res.overflow = 1'b1;
            return res;
        end
        p  = (c.porosity > cmtc_pkg::POROSITY_ONE) ? 64'd65536 : {47'd0, c.porosity};
        p0 = (c.initial_porosity > cmtc_pkg::POROSITY_ONE) ? 64'd65536
                                                           : {47'd0, c.initial_porosity};
        s_root = bit_root((64'd65536 - p) * (64'd65536 - p0), ROOT_BITS);
        num = s_root * {32'd0, c.diffusivity} * 64'd2;
        b16 = num / r;
        b30 = (num << 14) / r;
        vx = abs_vel(c.velocity_x);
        vy = abs_vel(c.velocity_y);
        vz = abs_vel(c.velocity_z);
        speed = bit_root(vx * vx + vy * vy + vz * vz, ROOT_BITS);
        if (b30 != 0 && c.density != 0 && speed != 0)
        begin
            lr = log2_fix(r);
            lre = lr + log2_fix({32'd0, c.density}) + log2_fix(speed)
                  - log2_fix({32'd0, c.viscosity}) - 64'sd31 * ONE_Q30;
            lt = (lre * 3) / 5 + LOG2_HALF_FIFTY_FIVE - (lr - 64'sd16 * ONE_Q30);
            if (lt >= 0)
            begin
                ip = lt / ONE_Q30;
            end
            else
            begin
                ip = -((-lt + ONE_Q30 - 1) / ONE_Q30);
            end
            f = lt - ip * ONE_Q30;
            acc = 64'd1 << 30;
            factor = 64'd2 << 30;
            for (int k = 1; k <= POW_BITS; k++)
            begin
                factor = bit_root(factor << 30, 32);
                if ((f >> (30 - k)) & 1)
                begin
                    acc = (acc * factor) >> 30;
                end
            end
            prod = {64'd0, b30} * {64'd0, acc};
            hi = prod[127:64];
            lo = prod[63:0];
            sh = ip - 44;
            if (sh >= 0)
            begin
                if (hi != 0 || sh >= 48 || lo > (OUT_MAX >> sh))
                begin
                    sat = 1'b1;
                end
                else
                begin
                    term = lo << sh;
                end
            end
            else
            begin
                kk = -sh;
                if (kk >= 128)
                begin
                    term = 64'd0;
                end
                else if (kk >= 64)
                begin
                    term = hi >> (kk - 64);
                end
                else
                begin
                    if ((hi >> kk) != 0)
                    begin
                        sat = 1'b1;
                    end
                    term = (lo >> kk) | (hi << (64 - kk));
                end
            end
        end
        if (!sat && term > OUT_MAX)
        begin
            sat = 1'b1;
        end
        total = sat ? OUT_MAX : b16 + term;
        if (total > OUT_MAX)
        begin
            total = OUT_MAX;
            sat = 1'b1;
        end
        res.transfer_coefficient = total[47:0];
        res.overflow = sat;
        return res;
    endfunction

    function automatic logic [31:0] spread32();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [16:0] random_porosity();
        if ($urandom_range(0, 7) == 0)
        begin
            return 17'($urandom);
        end
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic signed [31:0] random_velocity();
        if ($urandom_range(0, 9) == 0)
        begin
            return 32'sd0;
        end
        return $urandom_range(0, 1) ? $signed(spread32()) : -$signed(spread32());
    endfunction

    function automatic cmtc_pkg::item_t random_cell();
        cmtc_pkg::item_t c;
        c.porosity         = random_porosity();
        c.initial_porosity = random_porosity();
        c.density          = ($urandom_range(0, 15) == 0) ? 32'd0 : spread32();
        c.velocity_x       = random_velocity();
        c.velocity_y       = random_velocity();
        c.velocity_z       = random_velocity();
        c.viscosity        = ($urandom_range(0, 15) == 0) ? 32'd0 : spread32();
        c.diffusivity      = ($urandom_range(0, 15) == 0) ? 32'd0 : spread32();
        return c;
    endfunction

    function automatic cmtc_pkg::item_t make_cell(input logic [16:0] p,
                                                  input logic [16:0] p0,
                                                  input logic [31:0] rho,
                                                  input logic [31:0] vel,
                                                  input logic [31:0] mu,
                                                  input logic [31:0] alpha);
        cmtc_pkg::item_t c;
        c.porosity         = p;
        c.initial_porosity = p0;
        c.density          = rho;
        c.velocity_x       = vel;
        c.velocity_y       = -$signed(vel);
        c.velocity_z       = vel;
        c.viscosity        = mu;
        c.diffusivity      = alpha;
        return c;
    endfunction

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_cells.size() != 0 || item_valid || expected_results.size() != 0);
        repeat (140) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        took = item_valid && !item_stall;
        if (took)
        begin
            expected_results.push_back(predict_coefficient(item, radius));
        end
        if (result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %0h", result);
                errors++;
            end
            else
            begin
                if (result.transfer_coefficient
                    !== expected_results[0].transfer_coefficient)
                begin
                    $error("transfer_coefficient expected %0h actual %0h",
                           expected_results[0].transfer_coefficient,
                           result.transfer_coefficient);
                    errors++;
                end
                if (result.overflow !== expected_results[0].overflow)
                begin
                    $error("overflow expected %0b actual %0b",
                           expected_results[0].overflow, result.overflow);
                    errors++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || took))
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_cells.size() != 0)
            begin
                item <= pending_cells.pop_front();
                item_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 15);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 15);
            end
        end
    end

    initial
    begin
        logic [31:0] radii[6];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 32'd0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        radius = cmtc_pkg::RADIUS_RESET;
        errors = 0;
        gap_left = 0;
        stall_left = 0;
        quiet = 1'b0;
        took = 1'b0;
        radii = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0003_0000, 32'd0};
        radii[5] = $urandom_range(1, 32'h00FF_FFFF);

        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'd65536, 32'd65536,
                                          32'd65536, 32'd65536));
        pending_cells.push_back(make_cell(17'd65536, 17'd65536, 32'hFFFF_FFFF,
                                          32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cells.push_back(make_cell(17'h1FFFF, 17'h1FFFF, 32'd65536, 32'd65536,
                                          32'd65536, 32'd65536));
        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                          32'd1, 32'hFFFF_FFFF));
        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'd65536, 32'd65536,
                                          32'd0, 32'd65536));
        pending_cells.push_back(make_cell(17'd32768, 17'd16384, 32'd0, 32'd65536,
                                          32'd65536, 32'd65536));
        pending_cells.push_back(make_cell(17'd32768, 17'd16384, 32'd65536, 32'd0,
                                          32'd65536, 32'd65536));
        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'd1, 32'd1,
                                          32'hFFFF_FFFF, 32'd1));
        pending_cells.push_back(make_cell(17'd65535, 17'd1, 32'h0010_0000, 32'h8000_0000,
                                          32'd1, 32'h0001_0000));
        pending_cells.push_back(make_cell(17'd0, 17'd0, 32'd65536, 32'd65536,
                                          32'd65536, 32'd0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            @(negedge clk);
            cfg_write_en <= 1'b1;
            cfg_write_data <= radii[ph];
            radius = radii[ph];
            @(negedge clk);
            cfg_write_en <= 1'b0;
            quiet = (ph == 5);
            for (int n = 0; n < 122; n++)
            begin
                pending_cells.push_back(random_cell());
            end
        end
        wait_idle();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
